[src/sobel_edge_threshold_macros.svh]
// Assertion macros for the Sobel edge threshold block.
// Used by the top level only; compiled out when SYNTHESIS is defined.
`ifndef SOBEL_EDGE_THRESHOLD_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge outside reset
`define SET_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define SET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SET_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SET_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/set_pkg.sv]
// Shared types and constants of the Sobel edge threshold block.
// No dependencies; imported by set_front, set_back and the top level.
package set_pkg;

   // Sizes and limits
   localparam int SET_MAX_WIDTH  = 128;
   localparam int SET_MAX_HEIGHT = 128;
   localparam int SET_MIN_SIZE   = 3;
   localparam int SET_PIX_W      = 8;
   localparam int SET_SIZE_W     = 8;
   localparam int SET_MAG_W      = 11;
   localparam int SET_POS_W      = 7;

   // Queues between the parts and on the result side
   localparam int SET_FIFO_DEPTH = 4;
   localparam int SET_CNT_W      = $clog2(SET_FIFO_DEPTH + 1);

   // Control/status register map
   localparam int SET_CSR_W  = 2;
   localparam int SET_DATA_W = 11;
   localparam logic [SET_CSR_W-1:0] CSR_FRAME_WIDTH    = 2'd0;
   localparam logic [SET_CSR_W-1:0] CSR_FRAME_HEIGHT   = 2'd1;
   localparam logic [SET_CSR_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   // Reset values of the registers
   localparam logic [SET_SIZE_W-1:0] SET_WIDTH_RST     = 8'd64;
   localparam logic [SET_SIZE_W-1:0] SET_HEIGHT_RST    = 8'd64;
   localparam logic [SET_MAG_W-1:0]  SET_THRESHOLD_RST = 11'd50;

   typedef struct packed {
      logic [SET_SIZE_W-1:0] frame_width;
      logic [SET_SIZE_W-1:0] frame_height;
      logic [SET_MAG_W-1:0]  edge_threshold;
   } set_cfg_type;

   // One classified center: 3x3 neighborhood [row][col] plus its tags
   typedef struct packed {
      logic [2:0][2:0][SET_PIX_W-1:0] win;
      logic                           border;
      logic                           last;
      logic [SET_POS_W-1:0]           col;
      logic [SET_POS_W-1:0]           row;
   } set_item_type;

   typedef struct packed {
      logic                 edge_res;
      logic [SET_MAG_W-1:0] magnitude;
      logic [SET_POS_W-1:0] col;
      logic [SET_POS_W-1:0] row;
      logic                 last;
   } set_result_type;

endpackage

[src/set_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module set_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/set_fifo.sv]
// Small flop-based FIFO with occupancy count, used between and after the parts.
// No dependencies.
module set_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   // Pointer wrap and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   assign dout  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

[src/set_front.sv]
// Front part: pixel position counters, line stores, 3x3 window and classification.
// Depends on set_pkg and set_ram.
module set_front
   import set_pkg::*;
#(
   parameter int MAX_WIDTH = SET_MAX_WIDTH,
   localparam int CW = $clog2(MAX_WIDTH),
   localparam int XW = ((CW > SET_SIZE_W) ? CW : SET_SIZE_W) + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  set_cfg_type          cfg,
   input  logic                 req_push,
   input  logic [SET_PIX_W-1:0] req_pixel,
   output logic                 req_full,
   input  logic [SET_CNT_W-1:0] q_count,
   output logic                 q_push,
   output set_item_type         q_item
);

   // Position of the next pixel
   logic [CW-1:0]        col_ff, col_in;
   logic [SET_POS_W-1:0] row_ff, row_in;

   // Stage 0: accepted pixel waiting for its line store data
   logic                 s0_valid_ff, s0_valid_in;
   logic                 s0_emit_ff;
   logic                 s0_border_ff;
   logic                 s0_last_ff;
   logic [SET_POS_W-1:0] s0_col_ff;
   logic [SET_POS_W-1:0] s0_row_ff;
   logic [CW-1:0]        s0_addr_ff;
   logic [SET_PIX_W-1:0] s0_px_ff;

   logic [2:0][2:0][SET_PIX_W-1:0] win_ff, win_in;

   logic [SET_SIZE_W-1:0]   w_lo, w_eff, h_lo, h_eff;
   logic [XW-1:0]           col_ext, w_ext, w_m1;
   logic [SET_SIZE_W-1:0]   row_ext, h_m1;
   logic                    accept, at_last_col, at_last_row;
   logic                    emit, border, last;
   logic [XW-1:0]           cx_full;
   logic [2*SET_PIX_W-1:0]  ls_rdata;
   logic [SET_PIX_W-1:0]    ls_up, ls_mid;
   logic [SET_CNT_W:0]      credit_sum;

   // Frame size clamped into the supported range
   always_comb begin
      w_lo  = (cfg.frame_width < SET_SIZE_W'(SET_MIN_SIZE)) ?
              SET_SIZE_W'(SET_MIN_SIZE) : cfg.frame_width;
      w_eff = (int'(w_lo) > MAX_WIDTH) ? SET_SIZE_W'(MAX_WIDTH) : w_lo;
      h_lo  = (cfg.frame_height < SET_SIZE_W'(SET_MIN_SIZE)) ?
              SET_SIZE_W'(SET_MIN_SIZE) : cfg.frame_height;
      h_eff = (int'(h_lo) > SET_MAX_HEIGHT) ? SET_SIZE_W'(SET_MAX_HEIGHT) : h_lo;
   end

   // Room check: queue entries plus the one center still in stage 0
   assign credit_sum = {1'b0, q_count} + (SET_CNT_W + 1)'(s0_valid_ff && s0_emit_ff);
   assign req_full   = (credit_sum >= (SET_CNT_W + 1)'(SET_FIFO_DEPTH));
   assign accept     = req_push && !req_full;

   // Classification of the center left of and above the incoming pixel
   always_comb begin
      col_ext     = XW'(col_ff);
      w_ext       = XW'(w_eff);
      w_m1        = w_ext - XW'(1);
      row_ext     = SET_SIZE_W'(row_ff);
      h_m1        = h_eff - SET_SIZE_W'(1);
      at_last_col = (col_ext >= w_m1);
      at_last_row = (row_ext >= h_m1);
      emit        = (col_ff != '0) && (row_ff != '0);
      border      = (col_ff == CW'(1)) || (row_ff == SET_POS_W'(1)) ||
                    (col_ext >= w_ext) || (row_ext >= h_eff);
      last        = at_last_col && at_last_row;
      cx_full     = col_ext - XW'(1);
   end

   // Raster position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + SET_POS_W'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign s0_valid_in = accept;

   // Both line stores share one address: upper in the high byte, middle in the low
   set_ram #(
      .WIDTH (2 * SET_PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock (clock),
      .we    (s0_valid_ff),
      .waddr (s0_addr_ff),
      .wdata ({ls_mid, s0_px_ff}),
      .raddr (col_ff),
      .rdata (ls_rdata)
   );

   assign ls_up  = ls_rdata[2*SET_PIX_W-1:SET_PIX_W];
   assign ls_mid = ls_rdata[SET_PIX_W-1:0];

   // Window shift: older columns move left, new column enters on the right
   always_comb begin
      win_in = win_ff;
      if (s0_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = ls_up;
         win_in[1][2] = ls_mid;
         win_in[2][2] = s0_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s0_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s0_valid_ff <= s0_valid_in;
         win_ff      <= win_in;
      end
   end

   // Stage 0 payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s0_emit_ff   <= emit;
         s0_border_ff <= border;
         s0_last_ff   <= last;
         s0_col_ff    <= cx_full[SET_POS_W-1:0];
         s0_row_ff    <= row_ff - SET_POS_W'(1);
         s0_addr_ff   <= col_ff;
         s0_px_ff     <= req_pixel;
      end
   end

   // Hand the finished neighborhood to the queue
   assign q_push        = s0_valid_ff && s0_emit_ff;
   assign q_item.win    = win_in;
   assign q_item.border = s0_border_ff;
   assign q_item.last   = s0_last_ff;
   assign q_item.col    = s0_col_ff;
   assign q_item.row    = s0_row_ff;

endmodule

[src/set_back.sv]
// Back part: Sobel gradients, magnitude and threshold compare.
// Depends on set_pkg.
module set_back
   import set_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SET_MAG_W-1:0] edge_threshold,
   input  logic                 q_empty,
   input  set_item_type         q_item,
   output logic                 q_pop,
   input  logic [SET_CNT_W-1:0] o_count,
   output logic                 o_push,
   output set_result_type       o_result
);

   localparam int SW = SET_PIX_W + 2;   // weighted column/row sum, up to 1020

   logic                        a_valid_ff;
   logic signed [SET_MAG_W-1:0] gx_ff, gy_ff;
   logic                        a_border_ff;
   logic                        a_last_ff;
   logic [SET_POS_W-1:0]        a_col_ff;
   logic [SET_POS_W-1:0]        a_row_ff;

   logic [SW-1:0]               sx_pos, sx_neg, sy_pos, sy_neg;
   logic signed [SET_MAG_W-1:0] gx, gy;
   logic [SET_MAG_W-1:0]        ax, ay, mag;
   logic [SET_CNT_W:0]          credit_sum;

   // Pop only when the result queue can take it after stage A drains
   assign credit_sum = {1'b0, o_count} + (SET_CNT_W + 1)'(a_valid_ff);
   assign q_pop      = !q_empty && (credit_sum < (SET_CNT_W + 1)'(SET_FIFO_DEPTH));

   // Stage A: weighted sums and signed gradients
   always_comb begin
      sx_pos = SW'(q_item.win[0][2]) + SW'({q_item.win[1][2], 1'b0}) + SW'(q_item.win[2][2]);
      sx_neg = SW'(q_item.win[0][0]) + SW'({q_item.win[1][0], 1'b0}) + SW'(q_item.win[2][0]);
      sy_pos = SW'(q_item.win[2][0]) + SW'({q_item.win[2][1], 1'b0}) + SW'(q_item.win[2][2]);
      sy_neg = SW'(q_item.win[0][0]) + SW'({q_item.win[0][1], 1'b0}) + SW'(q_item.win[0][2]);
      gx     = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
      gy     = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= q_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         gx_ff       <= gx;
         gy_ff       <= gy;
         a_border_ff <= q_item.border;
         a_last_ff   <= q_item.last;
         a_col_ff    <= q_item.col;
         a_row_ff    <= q_item.row;
      end
   end

   // Stage B: magnitude and threshold, written into the result queue
   always_comb begin
      ax  = gx_ff[SET_MAG_W-1] ? SET_MAG_W'(-gx_ff) : SET_MAG_W'(gx_ff);
      ay  = gy_ff[SET_MAG_W-1] ? SET_MAG_W'(-gy_ff) : SET_MAG_W'(gy_ff);
      mag = a_border_ff ? '0 : ax + ay;
   end

   assign o_push             = a_valid_ff;
   assign o_result.edge_res  = !a_border_ff && (mag > edge_threshold);
   assign o_result.magnitude = mag;
   assign o_result.col       = a_col_ff;
   assign o_result.row       = a_row_ff;
   assign o_result.last      = a_last_ff;

endmodule

[src/sobel_edge_threshold.sv]
// Sobel 3x3 edge detector with magnitude threshold, streaming gray pixels.
// Pixels enter through req_push/req_full, one gray byte per request, in raster order.
// From pixel (x,y) with x>=1 and y>=1 the block makes one result for center
// (x-1,y-1); pixels in row 0 or column 0 give none. Results leave through
// rsp_empty/rsp_pop, oldest first, with magnitude |gx|+|gy|, edge flag, center
// position and a flag on the last result of a frame. The outer ring reads zero.
// On its way to the rsp_ ports a result passes stage 0, the center queue, stage A and the result queue.
// Throughput: one pixel per clock while req_full is low, set by the single read and
// single write port of the shared line store.
// CSR writes (csr_we, csr_index, csr_wdata) take effect at once and are meant
// for idle times; sizes are clamped to 3..MAX_WIDTH and 3..128.
// Reset clears the position counters, window and queues and loads the default
// registers (64x64, threshold 50); line stores keep their content.
// When rsp_pop stays low the 4-entry result queue fills, then the 4-entry
// center queue, then req_full rises; no request or result is lost.
`include "sobel_edge_threshold_macros.svh"

module sobel_edge_threshold
   import set_pkg::*;
#(
   parameter int MAX_WIDTH = SET_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Pixel requests
   input  logic                  req_push,
   input  logic [SET_PIX_W-1:0]  req_pixel,
   output logic                  req_full,
   // Results
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_edge_res,
   output logic [SET_MAG_W-1:0]  rsp_magnitude,
   output logic [SET_POS_W-1:0]  rsp_out_column,
   output logic [SET_POS_W-1:0]  rsp_out_row,
   output logic                  rsp_frame_last,
   // Register writes
   input  logic                  csr_we,
   input  logic [SET_CSR_W-1:0]  csr_index,
   input  logic [SET_DATA_W-1:0] csr_wdata
);

   set_cfg_type    cfg_ff, cfg_in;

   logic           q_push, q_pop, q_empty;
   set_item_type   q_item_wr, q_item_rd;
   logic [SET_CNT_W-1:0] q_count;

   logic           o_push, o_pop, o_empty;
   set_result_type o_result_wr, o_result_rd;
   logic [SET_CNT_W-1:0] o_count;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:    cfg_in.frame_width    = csr_wdata[SET_SIZE_W-1:0];
            CSR_FRAME_HEIGHT:   cfg_in.frame_height   = csr_wdata[SET_SIZE_W-1:0];
            CSR_EDGE_THRESHOLD: cfg_in.edge_threshold = csr_wdata[SET_MAG_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width    <= SET_WIDTH_RST;
         cfg_ff.frame_height   <= SET_HEIGHT_RST;
         cfg_ff.edge_threshold <= SET_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: counters, line stores, window, classification
   set_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_push  (req_push),
      .req_pixel (req_pixel),
      .req_full  (req_full),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_item    (q_item_wr)
   );

   // Center queue between front and back
   set_fifo #(
      .WIDTH ($bits(set_item_type)),
      .DEPTH (SET_FIFO_DEPTH)
   ) u_center_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_item_wr),
      .pop   (q_pop),
      .dout  (q_item_rd),
      .empty (q_empty),
      .count (q_count)
   );

   // Back: gradients and threshold
   set_back u_back (
      .clock          (clock),
      .reset          (reset),
      .edge_threshold (cfg_ff.edge_threshold),
      .q_empty        (q_empty),
      .q_item         (q_item_rd),
      .q_pop          (q_pop),
      .o_count        (o_count),
      .o_push         (o_push),
      .o_result       (o_result_wr)
   );

   // Result queue
   assign o_pop = rsp_pop && !o_empty;

   set_fifo #(
      .WIDTH ($bits(set_result_type)),
      .DEPTH (SET_FIFO_DEPTH)
   ) u_result_q (
      .clock (clock),
      .reset (reset),
      .push  (o_push),
      .din   (o_result_wr),
      .pop   (o_pop),
      .dout  (o_result_rd),
      .empty (o_empty),
      .count (o_count)
   );

   assign rsp_empty      = o_empty;
   assign rsp_edge_res   = o_result_rd.edge_res;
   assign rsp_magnitude  = o_result_rd.magnitude;
   assign rsp_out_column = o_result_rd.col;
   assign rsp_out_row    = o_result_rd.row;
   assign rsp_frame_last = o_result_rd.last;

   // Checks
   `SET_ASSERT_NEXT(a_center_follows_pixel, clock, reset, !(req_push && !req_full), !q_push, "center queued without a pixel taken the cycle before")
   `SET_ASSERT_IMPLY(a_result_q_room, clock, reset, o_push, (o_count < SET_CNT_W'(SET_FIFO_DEPTH)) || o_pop, "result queue overflow")
   `SET_ASSERT_IMPLY(a_center_q_room, clock, reset, q_push, (q_count < SET_CNT_W'(SET_FIFO_DEPTH)) || q_pop, "center queue overflow")
   `SET_ASSERT_IMPLY(a_edge_has_mag, clock, reset, !rsp_empty && rsp_edge_res, rsp_magnitude != '0, "edge flagged with zero magnitude")

endmodule

[verif/sobel_edge_threshold_test.sv]
// Self-checking test of the streaming Sobel edge detector sobel_edge_threshold.
// Depends on set_pkg for widths and register indexes; drives pixel requests,
// predicts every center result and compares each popped result field by field.
module sobel_edge_threshold_test;
   timeunit 1ns;
   timeprecision 1ps;
   import set_pkg::*;

   localparam int ITEM_TARGET   = 650;
   localparam int MAX_GAP       = 18;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;

   typedef enum {PACE_NONE, PACE_SOME, PACE_HEAVY} pace_type;
   typedef enum {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} texture_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic [SET_PIX_W-1:0]  req_pixel = '0;
   logic                  req_full;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_edge_res;
   logic [SET_MAG_W-1:0]  rsp_magnitude;
   logic [SET_POS_W-1:0]  rsp_out_column;
   logic [SET_POS_W-1:0]  rsp_out_row;
   logic                  rsp_frame_last;
   logic                  csr_we = 1'b0;
   logic [SET_CSR_W-1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [SET_DATA_W-1:0] csr_wdata = '0;

   // Predictor state: line stores, 3x3 neighborhood, position, register copies
   logic [SET_PIX_W-1:0] upper_row [SET_MAX_WIDTH] = '{default: '0};
   logic [SET_PIX_W-1:0] middle_row [SET_MAX_WIDTH] = '{default: '0};
   logic [SET_PIX_W-1:0] nbhd [3][3] = '{default: '{default: '0}};
   int col_pos = 0;
   int row_pos = 0;
   int cfg_width = int'(SET_WIDTH_RST);
   int cfg_height = int'(SET_HEIGHT_RST);
   int cfg_threshold = int'(SET_THRESHOLD_RST);

   // Pixels waiting to be offered, and center results still to arrive
   logic [SET_PIX_W-1:0] pixel_stream [$];
   set_result_type       centers_due [$];
   set_result_type       center_seen;
   int                   pixels_pending = 0;
   int                   items_queued = 0;
   int                   error_count = 0;

   pace_type sender_pace = PACE_SOME;
   pace_type receiver_pace = PACE_SOME;
   int    send_wait = 0;
   int    pop_wait = 0;
   int    hold_left = 0;
   bit    hold_request = 1'b0;

   sobel_edge_threshold dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_pixel      (req_pixel),
      .req_full       (req_full),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_edge_res   (rsp_edge_res),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_out_column (rsp_out_column),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int clamp_size(input int value, input int hi);
      return (value < SET_MIN_SIZE) ? SET_MIN_SIZE : ((value > hi) ? hi : value);
   endfunction

   function automatic int draw_gap(input pace_type pace);
      case (pace)
         PACE_NONE: return 0;
         PACE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
         default:   return $urandom_range(0, MAX_GAP);
      endcase
   endfunction

   // Advance the detector by one pixel; queue the center result it produces
   function automatic void sobel_predict(input logic [SET_PIX_W-1:0] px);
      int w, h, x, y, slot, r, gx, gy, mag;
      logic [SET_PIX_W-1:0] up, mid;
      bit border;
      set_result_type res;
      w = clamp_size(cfg_width, SET_MAX_WIDTH);
      h = clamp_size(cfg_height, SET_MAX_HEIGHT);
      x = col_pos;
      y = row_pos;
      slot = x % SET_MAX_WIDTH;
      up = upper_row[slot];
      mid = middle_row[slot];
      upper_row[slot] = mid;
      middle_row[slot] = px;
      for (r = 0; r < 3; r++) begin
         nbhd[r][0] = nbhd[r][1];
         nbhd[r][1] = nbhd[r][2];
      end
      nbhd[0][2] = up;
      nbhd[1][2] = mid;
      nbhd[2][2] = px;

      if (x >= 1 && y >= 1) begin
         // outer ring, and anything at or past the last column or row, reads zero
         border = (x - 1 == 0) || (y - 1 == 0) || (x - 1 >= w - 1) || (y - 1 >= h - 1);
         mag = 0;
         if (!border) begin
            gx = (int'(nbhd[0][2]) + 2 * int'(nbhd[1][2]) + int'(nbhd[2][2]))
               - (int'(nbhd[0][0]) + 2 * int'(nbhd[1][0]) + int'(nbhd[2][0]));
            gy = (int'(nbhd[2][0]) + 2 * int'(nbhd[2][1]) + int'(nbhd[2][2]))
               - (int'(nbhd[0][0]) + 2 * int'(nbhd[0][1]) + int'(nbhd[0][2]));
            mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
         end
         res.edge_res  = !border && (mag > cfg_threshold);
         res.magnitude = SET_MAG_W'(mag);
         res.col       = SET_POS_W'(x - 1);
         res.row       = SET_POS_W'(y - 1);
         res.last      = (x >= w - 1) && (y >= h - 1);
         centers_due.push_back(res);
      end

      // position wraps at once if a size change left it past the end
      if (x >= w - 1) begin
         col_pos = 0;
         row_pos = (y >= h - 1) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endfunction

   function automatic void check_field(input string name, input logic [SET_MAG_W-1:0] want,
                                       input logic [SET_MAG_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic write_reg(input logic [SET_CSR_W-1:0] index, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= SET_DATA_W'(value);
      case (index)
         CSR_FRAME_WIDTH:    cfg_width = value & ((1 << SET_SIZE_W) - 1);
         CSR_FRAME_HEIGHT:   cfg_height = value & ((1 << SET_SIZE_W) - 1);
         CSR_EDGE_THRESHOLD: cfg_threshold = value & ((1 << SET_MAG_W) - 1);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic offer_pixel(input logic [SET_PIX_W-1:0] value);
      pixel_stream.push_back(value);
      pixels_pending++;
      items_queued++;
   endtask

   task automatic queue_pixels(input int count, input texture_type texture);
      logic [SET_PIX_W-1:0] value;
      value = SET_PIX_W'($urandom_range(0, 255));
      repeat (count) begin
         case (texture)
            TEX_NOISE:  value = SET_PIX_W'($urandom_range(0, 255));
            TEX_BINARY: value = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            default:    value = SET_PIX_W'(value + $urandom_range(0, 16) - 8);
         endcase
         offer_pixel(value);
      end
   endtask

   // Idle means every request taken and every result popped, plus drain time
   task automatic settle();
      while (pixels_pending != 0 || centers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: one pixel per request, random gaps between requests
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_push && !req_full) begin
            sobel_predict(req_pixel);
            pixels_pending--;
            send_wait = draw_gap(sender_pace);
         end
         if (req_push && req_full) begin
            // blocked: hold the request as it is
         end else if (send_wait > 0) begin
            send_wait--;
            req_push <= 1'b0;
         end else if (pixel_stream.size() > 0) begin
            req_push <= 1'b1;
            req_pixel <= pixel_stream.pop_front();
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Result monitor: pops with random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (centers_due.size() == 0) begin
               $error("unexpected result for column %0d row %0d", rsp_out_column, rsp_out_row);
               error_count++;
            end else begin
               center_seen = centers_due.pop_front();
               check_field("edge_res", SET_MAG_W'(center_seen.edge_res),
                           SET_MAG_W'(rsp_edge_res));
               check_field("magnitude", center_seen.magnitude, rsp_magnitude);
               check_field("out_column", SET_MAG_W'(center_seen.col),
                           SET_MAG_W'(rsp_out_column));
               check_field("out_row", SET_MAG_W'(center_seen.row), SET_MAG_W'(rsp_out_row));
               check_field("frame_last", SET_MAG_W'(center_seen.last),
                           SET_MAG_W'(rsp_frame_last));
            end
            pop_wait = draw_gap(receiver_pace);
         end
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (pop_wait > 0) begin
            pop_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   initial begin
      logic [SET_PIX_W-1:0] step_frame [9] = '{0, 0, 0, 0, 0, 0, 255, 255, 255};
      logic [SET_PIX_W-1:0] corner_frame [16] = '{0, 0, 0, 0, 0, 0, 0, 0,
                                                  0, 0, 0, 255, 0, 0, 255, 255};
      int width_val, height_val, thr_val, frame_px;
      texture_type texture;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Sizes below the minimum clamp to 3x3; top threshold never marks an edge
      write_reg(CSR_FRAME_WIDTH, 1);
      write_reg(CSR_FRAME_HEIGHT, 0);
      write_reg(CSR_EDGE_THRESHOLD, 2047);
      foreach (step_frame[i]) offer_pixel(step_frame[i]);
      settle();

      // 4x4: flat center, magnitude equal to threshold, and a strong corner
      write_reg(CSR_FRAME_WIDTH, 4);
      write_reg(CSR_FRAME_HEIGHT, 4);
      write_reg(CSR_EDGE_THRESHOLD, 510);
      foreach (corner_frame[i]) offer_pixel(corner_frame[i]);
      settle();

      // Full-width frame fills every line store column; receiver backs off
      // for a long stretch meanwhile so the block stalls its input
      sender_pace = PACE_NONE;
      receiver_pace = PACE_SOME;
      write_reg(CSR_FRAME_WIDTH, 255);
      write_reg(CSR_FRAME_HEIGHT, 2);
      write_reg(CSR_EDGE_THRESHOLD, $urandom_range(200, 900));
      hold_request = 1'b1;
      queue_pixels(SET_MIN_SIZE * SET_MAX_WIDTH, TEX_NOISE);
      settle();

      // Random frames; partial ones make the next size change land mid-frame
      while (items_queued < ITEM_TARGET) begin
         sender_pace = pace_type'($urandom_range(0, 2));
         receiver_pace = pace_type'($urandom_range(0, 2));
         texture = texture_type'($urandom_range(0, 2));
         case ($urandom_range(0, 7))
            0:       width_val = $urandom_range(0, 2);
            1:       width_val = $urandom_range(100, 255);
            default: width_val = $urandom_range(3, 14);
         endcase
         case ($urandom_range(0, 7))
            0:       height_val = $urandom_range(0, 2);
            1:       height_val = $urandom_range(129, 255);
            default: height_val = $urandom_range(3, 8);
         endcase
         case ($urandom_range(0, 5))
            0:       thr_val = 0;
            1:       thr_val = $urandom_range(1530, 2047);
            2:       thr_val = $urandom_range(0, 2047);
            default: thr_val = $urandom_range(100, 900);
         endcase
         write_reg(CSR_FRAME_WIDTH, width_val);
         write_reg(CSR_FRAME_HEIGHT, height_val);
         write_reg(CSR_EDGE_THRESHOLD, thr_val);
         frame_px = clamp_size(width_val, SET_MAX_WIDTH) * clamp_size(height_val, SET_MAX_HEIGHT);
         if (frame_px <= 200 && $urandom_range(0, 3) != 0)
            queue_pixels(frame_px, texture);
         else
            queue_pixels($urandom_range(1, (frame_px - 1 < 60) ? frame_px - 1 : 60), texture);
         settle();
      end

      if (error_count == 0)
         $display("sobel_edge_threshold test passed");
      else
         $display("sobel_edge_threshold test failed");
      $finish;
   end

   // Watchdog far beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("sobel_edge_threshold test failed");
      $finish;
   end

endmodule
